// File: rtl/sele_pkg.sv
package sele_pkg;

  localparam int Capacity = 256;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int CodeW = 15;
  localparam int ScoreW = 16;
  localparam int EntryW = CodeW + ScoreW;

  typedef logic [EntryW-1:0] entry_t;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_SET    = 3'd1,
    KIND_MTF    = 3'd2,
    KIND_SORT   = 3'd3,
    KIND_FIND   = 3'd4,
    KIND_TRUNC  = 3'd5,
    KIND_CLEAR  = 3'd6,
    KIND_READ   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DUP   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_ADDR,
    S_SCAN_CHK,
    S_RD_ADDR,
    S_RD_DATA,
    S_MTF_ADDR,
    S_MTF_SHIFT,
    S_SORT_OUTER,
    S_SORT_ADDR,
    S_SORT_CMP,
    S_DONE
  } state_t;

  // Unsigned key that orders like the signed packed value.
  function automatic logic [EntryW-1:0] key_of(input entry_t e);
    key_of = {~e[EntryW-1], e[EntryW-2:0]};
  endfunction

endpackage

// File: rtl/scored_entry_list_engine_unit.sv
// Append and find scan the list one entry at a time, address then compare.
// Move to front shifts the entries ahead of the position down by one, then
// writes the held entry at the front; sort is an insertion sort.
// Throughput: one request at a time; in_stall is high until the result is taken.
// Reset: rst_n (synchronous) empties the list; entry memory is not cleared.
module scored_entry_list_engine_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_kind,
  input  logic [sele_pkg::CodeW-1:0]          in_entry_code,
  input  logic signed [sele_pkg::ScoreW-1:0]  in_entry_score,
  input  logic [7:0]                          in_position,
  input  logic [8:0]                          in_new_length,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [8:0]                          out_list_length,
  output logic                                out_found,
  output logic [7:0]                          out_found_position,
  output logic [sele_pkg::CodeW-1:0]          out_read_code,
  output logic signed [sele_pkg::ScoreW-1:0]  out_read_score
);

  localparam int IW = sele_pkg::IdxW;
  localparam int CW = sele_pkg::CntW;

  sele_pkg::state_t state_r, state_nxt;
  sele_pkg::kind_t  kind_r, kind_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  sele_pkg::entry_t hold_r, hold_nxt;
  logic [sele_pkg::CodeW-1:0] code_r, code_nxt;
  logic [sele_pkg::ScoreW-1:0] score_r, score_nxt;
  logic [1:0] status_r, status_nxt;
  logic found_r, found_nxt;
  logic [7:0] fpos_r, fpos_nxt;
  logic [sele_pkg::CodeW-1:0] rcode_r, rcode_nxt;
  logic [sele_pkg::ScoreW-1:0] rscore_r, rscore_nxt;

  // Entry memory, one port each for write and registered read.
  sele_pkg::entry_t mem [sele_pkg::Capacity];
  sele_pkg::entry_t rd_data_r;
  logic [IW-1:0] rd_addr, wr_addr;
  logic wr_en;
  sele_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  logic [sele_pkg::ScoreW-1:0] sat_score;
  logic accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != sele_pkg::S_IDLE);
  assign out_valid = (state_r == sele_pkg::S_DONE);
  assign sat_score = (in_entry_score == {1'b1, {(sele_pkg::ScoreW-1){1'b0}}}) ?
                     {1'b1, {(sele_pkg::ScoreW-2){1'b0}}, 1'b1} : in_entry_score;

  // Sequencer for all operations.
  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    count_nxt = count_r;
    i_nxt = i_r;
    j_nxt = j_r;
    hold_nxt = hold_r;
    code_nxt = code_r;
    score_nxt = score_r;
    status_nxt = status_r;
    found_nxt = found_r;
    fpos_nxt = fpos_r;
    rcode_nxt = rcode_r;
    rscore_nxt = rscore_r;
    rd_addr = i_r[IW-1:0];
    wr_addr = j_r[IW-1:0];
    wr_en = 1'b0;
    wr_data = hold_r;
    unique case (state_r)
      sele_pkg::S_IDLE: begin
        if (accept) begin
          kind_nxt = sele_pkg::kind_t'(in_kind);
          code_nxt = in_entry_code;
          score_nxt = sat_score;
          status_nxt = sele_pkg::ST_OK;
          found_nxt = 1'b0;
          fpos_nxt = '0;
          rcode_nxt = '0;
          rscore_nxt = '0;
          i_nxt = '0;
          unique case (sele_pkg::kind_t'(in_kind))
            sele_pkg::KIND_APPEND, sele_pkg::KIND_FIND: state_nxt = sele_pkg::S_SCAN_ADDR;
            sele_pkg::KIND_SET, sele_pkg::KIND_READ, sele_pkg::KIND_MTF: begin
              if (CW'(in_position) >= count_r) begin
                status_nxt = sele_pkg::ST_RANGE;
                state_nxt = sele_pkg::S_DONE;
              end else begin
                i_nxt = CW'(in_position);
                state_nxt = sele_pkg::S_RD_ADDR;
              end
            end
            sele_pkg::KIND_SORT: begin
              if (count_r <= CW'(1)) state_nxt = sele_pkg::S_DONE;
              else begin
                i_nxt = count_r - CW'(1);
                state_nxt = sele_pkg::S_SORT_OUTER;
              end
            end
            sele_pkg::KIND_TRUNC: begin
              if (CW'(in_new_length) > count_r) status_nxt = sele_pkg::ST_RANGE;
              else count_nxt = CW'(in_new_length);
              state_nxt = sele_pkg::S_DONE;
            end
            sele_pkg::KIND_CLEAR: begin
              count_nxt = '0;
              state_nxt = sele_pkg::S_DONE;
            end
            default: state_nxt = sele_pkg::S_DONE;
          endcase
        end
      end
      // Linear scan for a code: address then compare.
      sele_pkg::S_SCAN_ADDR: begin
        if (i_r >= count_r) begin
          if (kind_r == sele_pkg::KIND_APPEND) begin
            if (count_r >= CW'(sele_pkg::Capacity)) status_nxt = sele_pkg::ST_FULL;
            else begin
              wr_en = 1'b1;
              wr_addr = count_r[IW-1:0];
              wr_data = {score_r, code_r};
              count_nxt = count_r + CW'(1);
            end
          end
          state_nxt = sele_pkg::S_DONE;
        end else begin
          state_nxt = sele_pkg::S_SCAN_CHK;
        end
      end
      sele_pkg::S_SCAN_CHK: begin
        if (rd_data_r[sele_pkg::CodeW-1:0] == code_r) begin
          if (kind_r == sele_pkg::KIND_APPEND) status_nxt = sele_pkg::ST_DUP;
          else begin
            found_nxt = 1'b1;
            fpos_nxt = 8'(i_r);
          end
          state_nxt = sele_pkg::S_DONE;
        end else begin
          i_nxt = i_r + CW'(1);
          state_nxt = sele_pkg::S_SCAN_ADDR;
        end
      end
      sele_pkg::S_RD_ADDR: state_nxt = sele_pkg::S_RD_DATA;
      sele_pkg::S_RD_DATA: begin
        unique case (kind_r)
          sele_pkg::KIND_SET: begin
            wr_en = 1'b1;
            wr_addr = i_r[IW-1:0];
            wr_data = {score_r, rd_data_r[sele_pkg::CodeW-1:0]};
            state_nxt = sele_pkg::S_DONE;
          end
          sele_pkg::KIND_MTF: begin
            hold_nxt = rd_data_r;
            j_nxt = i_r;
            state_nxt = sele_pkg::S_MTF_ADDR;
          end
          default: begin
            rcode_nxt = rd_data_r[sele_pkg::CodeW-1:0];
            rscore_nxt = rd_data_r[sele_pkg::EntryW-1:sele_pkg::CodeW];
            state_nxt = sele_pkg::S_DONE;
          end
        endcase
      end
      // Move to front: copy entry j-1 to j with j counting down, then place held entry.
      sele_pkg::S_MTF_ADDR: begin
        if (j_r == '0) begin
          wr_en = 1'b1;
          wr_addr = '0;
          wr_data = hold_r;
          state_nxt = sele_pkg::S_DONE;
        end else begin
          rd_addr = IW'(j_r - CW'(1));
          state_nxt = sele_pkg::S_MTF_SHIFT;
        end
      end
      sele_pkg::S_MTF_SHIFT: begin
        wr_en = 1'b1;
        wr_addr = j_r[IW-1:0];
        wr_data = rd_data_r;
        j_nxt = j_r - CW'(1);
        state_nxt = sele_pkg::S_MTF_ADDR;
      end
      // Insertion sort, outer index i from n-2 down to 0.
      sele_pkg::S_SORT_OUTER: begin
        if (i_r == '0) state_nxt = sele_pkg::S_DONE;
        else begin
          i_nxt = i_r - CW'(1);
          rd_addr = IW'(i_r - CW'(1));
          j_nxt = i_r - CW'(1);
          state_nxt = sele_pkg::S_SORT_ADDR;
        end
      end
      sele_pkg::S_SORT_ADDR: begin
        // Data for entry i arrives now; hold it, then read j+1.
        if (j_r == i_r) hold_nxt = rd_data_r;
        if (j_r + CW'(1) >= count_r) begin
          wr_en = 1'b1;
          wr_addr = j_r[IW-1:0];
          wr_data = (j_r == i_r) ? rd_data_r : hold_r;
          state_nxt = sele_pkg::S_SORT_OUTER;
        end else begin
          rd_addr = IW'(j_r + CW'(1));
          state_nxt = sele_pkg::S_SORT_CMP;
        end
      end
      sele_pkg::S_SORT_CMP: begin
        if (sele_pkg::key_of(hold_r) < sele_pkg::key_of(rd_data_r)) begin
          wr_en = 1'b1;
          wr_addr = j_r[IW-1:0];
          wr_data = rd_data_r;
          j_nxt = j_r + CW'(1);
          if (j_r + CW'(2) >= count_r) begin
            wr_addr = j_r[IW-1:0];
            state_nxt = sele_pkg::S_SORT_ADDR;
          end else begin
            rd_addr = IW'(j_r + CW'(2));
            state_nxt = sele_pkg::S_SORT_CMP;
          end
          if (j_r + CW'(2) >= count_r) begin
            // Next step sees j+1 at the end and writes the held entry.
            state_nxt = sele_pkg::S_SORT_ADDR;
          end
        end else begin
          wr_en = 1'b1;
          wr_addr = j_r[IW-1:0];
          wr_data = hold_r;
          state_nxt = sele_pkg::S_SORT_OUTER;
        end
      end
      sele_pkg::S_DONE: begin
        if (!out_stall) state_nxt = sele_pkg::S_IDLE;
      end
      default: state_nxt = sele_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sele_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    hold_r <= hold_nxt;
    code_r <= code_nxt;
    score_r <= score_nxt;
    status_r <= status_nxt;
    found_r <= found_nxt;
    fpos_r <= fpos_nxt;
    rcode_r <= rcode_nxt;
    rscore_r <= rscore_nxt;
  end

  assign out_status = status_r;
  assign out_list_length = 9'(count_r);
  assign out_found = found_r;
  assign out_found_position = fpos_r;
  assign out_read_code = rcode_r;
  assign out_read_score = rscore_r;

  // The list never grows past its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(sele_pkg::Capacity)) else $error("list count over capacity");

  // Size only changes when a request starts or an append finishes.
  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > $past(count_r)) |-> $past(state_r == sele_pkg::S_SCAN_ADDR))
    else $error("list grew outside append");

  // A miss on find reports position zero.
  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_found_position == '0))
    else $error("found position without a hit");

  // The result holds while stalled.
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

// File: bench/scored_entry_list_engine_unit_tb.sv
module scored_entry_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected fields of one result.
  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  list_length;
    logic        found;
    logic [7:0]  found_position;
    logic [14:0] read_code;
    logic [15:0] read_score;
  } list_result_t;

  // Model of the list that computes the result of each request.
  class list_scoreboard;
    logic [14:0] codes [sele_pkg::Capacity];
    logic signed [15:0] scores [sele_pkg::Capacity];
    int unsigned count;
    list_result_t pending [$];
    int errors;

    function void clear_state();
      count = 0;
      errors = 0;
      pending.delete();
    endfunction

    function logic [30:0] order_key(logic [14:0] c, logic signed [15:0] s);
      return {~s[15], s[14:0], c};
    endfunction

    function int locate_code(logic [14:0] c);
      for (int i = 0; i < count; i++)
        if (codes[i] == c) return i;
      return -1;
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(sele_pkg::kind_t kind, logic [14:0] code,
                               logic signed [15:0] raw, logic [7:0] pos, logic [8:0] len);
      list_result_t r;
      logic signed [15:0] s;
      logic [14:0] c;
      int w, j;
      r = '0;
      s = (raw == -16'sd32768) ? -16'sd32767 : raw;
      case (kind)
        sele_pkg::KIND_APPEND: begin
          if (locate_code(code) >= 0) r.status = sele_pkg::ST_DUP;
          else if (count >= sele_pkg::Capacity) r.status = sele_pkg::ST_FULL;
          else begin
            codes[count] = code;
            scores[count] = s;
            count++;
          end
        end
        sele_pkg::KIND_SET: begin
          if (pos >= count) r.status = sele_pkg::ST_RANGE;
          else scores[pos] = s;
        end
        sele_pkg::KIND_MTF: begin
          if (pos >= count) r.status = sele_pkg::ST_RANGE;
          else begin
            c = codes[pos];
            s = scores[pos];
            for (j = pos; j > 0; j--) begin
              codes[j] = codes[j-1];
              scores[j] = scores[j-1];
            end
            codes[0] = c;
            scores[0] = s;
          end
        end
        sele_pkg::KIND_SORT: begin
          // Insertion sort from the tail, stable, descending.
          for (int i = int'(count) - 2; i >= 0; i--) begin
            c = codes[i];
            s = scores[i];
            j = i;
            while (j + 1 < count && order_key(c, s) < order_key(codes[j+1], scores[j+1])) begin
              codes[j] = codes[j+1];
              scores[j] = scores[j+1];
              j++;
            end
            codes[j] = c;
            scores[j] = s;
          end
        end
        sele_pkg::KIND_FIND: begin
          w = locate_code(code);
          if (w >= 0) begin
            r.found = 1'b1;
            r.found_position = w[7:0];
          end
        end
        sele_pkg::KIND_TRUNC: begin
          if (len > count) r.status = sele_pkg::ST_RANGE;
          else count = len;
        end
        sele_pkg::KIND_CLEAR: count = 0;
        default: begin
          if (pos >= count) r.status = sele_pkg::ST_RANGE;
          else begin
            r.read_code = codes[pos];
            r.read_score = scores[pos];
          end
        end
      endcase
      r.list_length = count[8:0];
      pending.push_back(r);
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(list_result_t got);
      list_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status != exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.list_length != exp.list_length) begin
        $display("%0t: list_length exp %0d got %0d", $time, exp.list_length,
                 got.list_length);
        errors++;
      end
      if (got.found != exp.found) begin
        $display("%0t: found exp %0d got %0d", $time, exp.found, got.found);
        errors++;
      end
      if (got.found_position != exp.found_position) begin
        $display("%0t: found_position exp %0d got %0d", $time, exp.found_position,
                 got.found_position);
        errors++;
      end
      if (got.read_code != exp.read_code) begin
        $display("%0t: read_code exp %0d got %0d", $time, exp.read_code, got.read_code);
        errors++;
      end
      if (got.read_score != exp.read_score) begin
        $display("%0t: read_score exp %0d got %0d", $time, $signed(exp.read_score),
                 $signed(got.read_score));
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = '0;
  logic [14:0] in_entry_code = '0;
  logic signed [15:0] in_entry_score = '0;
  logic [7:0] in_position = '0;
  logic [8:0] in_new_length = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [1:0] out_status;
  logic [8:0] out_list_length;
  logic out_found;
  logic [7:0] out_found_position;
  logic [14:0] out_read_code;
  logic signed [15:0] out_read_score;

  int send_idle_pct = 29;
  int recv_idle_pct = 85;
  list_scoreboard board;
  logic [14:0] used_codes [$];

  scored_entry_list_engine_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stall, check on each accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_status, out_list_length, out_found, out_found_position,
                          out_read_code, out_read_score});
    if (!rst_n) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Sends one request and notes it when accepted; valid stays up until the
  // next request or an idle cycle takes it down.
  task automatic send_request(sele_pkg::kind_t k, logic [14:0] c, logic [15:0] s,
                              logic [7:0] p, logic [8:0] l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_entry_code <= c;
    in_entry_score <= s;
    in_position <= p;
    in_new_length <= l;
    do @(posedge clk); while (in_stall);
    board.note_request(k, c, s, p, l);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Code that is already present about a third of the time, so duplicates and finds hit.
  function automatic logic [14:0] pick_code();
    if (used_codes.size() != 0 && $urandom_range(2) == 0)
      return used_codes[$urandom_range(used_codes.size() - 1)];
    return 15'($urandom_range(32767));
  endfunction

  function automatic logic [7:0] pick_pos();
    int unsigned n;
    n = board.count;
    if (n != 0 && $urandom_range(5) != 0) return 8'($urandom_range(n - 1));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_phase(int items);
    sele_pkg::kind_t k;
    logic [14:0] c;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: k = sele_pkg::KIND_APPEND;
        6, 7: k = sele_pkg::KIND_SET;
        8, 9: k = sele_pkg::KIND_MTF;
        10: k = sele_pkg::KIND_SORT;
        11, 12: k = sele_pkg::KIND_FIND;
        13: k = sele_pkg::KIND_TRUNC;
        14: k = ($urandom_range(3) == 0) ? sele_pkg::KIND_CLEAR : sele_pkg::KIND_READ;
        default: k = sele_pkg::KIND_READ;
      endcase
      // Keep the list short most of the time so sorts stay cheap.
      if (k == sele_pkg::KIND_APPEND && board.count > 40 && $urandom_range(3) != 0)
        k = sele_pkg::KIND_TRUNC;
      c = pick_code();
      used_codes.push_back(c);
      if (used_codes.size() > 64) void'(used_codes.pop_front());
      send_request(k, c, 16'($urandom()), pick_pos(),
                   ($urandom_range(4) == 0) ? 9'($urandom_range(511))
                                            : 9'($urandom_range(board.count)));
    end
  endtask

  // Directed and random stimulus.
  initial begin
    board = new();
    board.clear_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(sele_pkg::KIND_READ, 0, 0, 0, 0);
    send_request(sele_pkg::KIND_SORT, 0, 0, 0, 0);
    send_request(sele_pkg::KIND_APPEND, 15'h7fff, 16'h8000, 0, 0);
    send_request(sele_pkg::KIND_APPEND, 15'h0000, 16'h7fff, 0, 0);
    send_request(sele_pkg::KIND_APPEND, 15'h7fff, 16'h0000, 0, 0);
    send_request(sele_pkg::KIND_SORT, 0, 0, 0, 0);
    send_request(sele_pkg::KIND_APPEND, 15'h2aaa, 16'h7fff, 0, 0);
    send_request(sele_pkg::KIND_APPEND, 15'h5555, 16'h5555, 0, 0);
    send_request(sele_pkg::KIND_SET, 0, 16'h8000, 1, 0);
    send_request(sele_pkg::KIND_SET, 0, 1, 255, 0);
    send_request(sele_pkg::KIND_MTF, 0, 0, 3, 0);
    send_request(sele_pkg::KIND_MTF, 0, 0, 200, 0);
    send_request(sele_pkg::KIND_SORT, 0, 0, 0, 0);
    send_request(sele_pkg::KIND_FIND, 15'h5555, 0, 0, 0);
    send_request(sele_pkg::KIND_FIND, 15'h1234, 0, 0, 0);
    send_request(sele_pkg::KIND_READ, 0, 0, 0, 0);
    send_request(sele_pkg::KIND_READ, 0, 0, 3, 0);
    send_request(sele_pkg::KIND_READ, 0, 0, 255, 0);
    send_request(sele_pkg::KIND_TRUNC, 0, 0, 0, 256);
    send_request(sele_pkg::KIND_TRUNC, 0, 0, 0, 511);
    send_request(sele_pkg::KIND_TRUNC, 0, 0, 0, 2);
    send_request(sele_pkg::KIND_CLEAR, 0, 0, 0, 0);
    // Fill to capacity, then hit the full case.
    send_idle_pct = 0;
    for (int i = 0; i < sele_pkg::Capacity; i++)
      send_request(sele_pkg::KIND_APPEND, 15'(i * 3), 16'(i), 0, 0);
    send_request(sele_pkg::KIND_APPEND, 15'h7ffe, 0, 0, 0);
    send_request(sele_pkg::KIND_FIND, 15'(255 * 3), 0, 0, 0);
    send_request(sele_pkg::KIND_MTF, 0, 0, 255, 0);
    send_request(sele_pkg::KIND_READ, 0, 0, 255, 0);
    send_request(sele_pkg::KIND_TRUNC, 0, 0, 0, 10);
    send_idle_pct = 29;

    random_phase(300);
    // Hold the sender off until the pipeline is empty.
    wait_drained();
    send_idle_pct = 85;
    recv_idle_pct = 29;
    random_phase(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(400);

    wait_drained();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("scored_entry_list_engine_unit_tb: done, clean");
    else
      $display("scored_entry_list_engine_unit_tb: done, errors");
    $finish;
  end

  // Run limit.
  initial begin
    #60ms;
    $display("scored_entry_list_engine_unit_tb: done, errors");
    $finish;
  end
endmodule

// File: sim.f
rtl/sele_pkg.sv
rtl/scored_entry_list_engine_unit.sv
bench/scored_entry_list_engine_unit_tb.sv
